@@ hw/rtl/mssp_pkg.sv @@
// Shared types and constants for the five-axis servo slew limiter with PWM mapping.
`timescale 1ns / 1ps

package mssp_pkg;

  localparam int NUM_AXES = 5;
  localparam int CMD_W    = 2;
  localparam int AXIS_W   = 3;
  localparam int ANGLE_W  = 9;
  localparam int CMP_W    = 8;

  // Depth of the result queue; at least three keeps one item per cycle while the consumer does not stall.
  localparam int RES_DEPTH_DEF = 4;

  localparam logic [CMD_W-1:0] CMD_SET_TARGET = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK       = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET_BOTH   = 2'd2;

  localparam logic [ANGLE_W-1:0] AXIS_MAX [NUM_AXES] = '{
    9'd270, 9'd180, 9'd270, 9'd270, 9'd180
  };

  typedef logic [NUM_AXES-1:0][ANGLE_W-1:0] angle_vec_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [AXIS_W-1:0]  axis_index;
    logic [ANGLE_W-1:0] angle;
  } req_item_t;

  typedef struct packed {
    logic [CMP_W-1:0] compare_axis1;
    logic [CMP_W-1:0] compare_axis2;
    logic [CMP_W-1:0] compare_axis3;
    logic [CMP_W-1:0] compare_axis4;
    logic [CMP_W-1:0] compare_axis5;
    logic             settled;
  } rsp_item_t;

endpackage

@@ hw/rtl/mssp_map.sv @@
// Angle to PWM compare mapping for all five axes, plus the settled flag.
`timescale 1ns / 1ps

module mssp_map
  import mssp_pkg::*;
(
  input  angle_vec_t cur_angle,
  input  angle_vec_t tgt_angle,
  output rsp_item_t  result
);

  // Each map is floor(b * num / den) with num/den reduced, computed exactly as
  // (b * ceil(2^16 * num / den)) >> 16. The rounding error of the multiplier
  // times the largest b stays below 2^16 / den, so the floor never shifts.
  localparam int PROD_W    = 26;
  localparam int MAP_SHIFT = 16;

  localparam logic [16:0] MUL_AX1 = 17'd48546;   // 20/27
  localparam logic [16:0] MUL_AX2 = 17'd69177;   // 19/18
  localparam logic [16:0] MUL_AX3 = 17'd42478;   // 35/54
  localparam logic [16:0] MUL_AX4 = 17'd42478;   // 35/54
  localparam logic [16:0] MUL_AX5 = 17'd72818;   // 10/9

  localparam logic [CMP_W-1:0] OFF_AX1 = 8'd55;
  localparam logic [CMP_W-1:0] OFF_AX2 = 8'd50;
  localparam logic [CMP_W-1:0] OFF_AX3 = 8'd50;
  localparam logic [CMP_W-1:0] OFF_AX4 = 8'd55;
  localparam logic [CMP_W-1:0] OFF_AX5 = 8'd50;

  logic [ANGLE_W-1:0] span [NUM_AXES];
  logic [PROD_W-1:0]  prod [NUM_AXES];
  logic [CMP_W-1:0]   quot [NUM_AXES];

  // The first three axes run inverted: the distance from the axis maximum.
  assign span[0] = AXIS_MAX[0] - cur_angle[0];
  assign span[1] = AXIS_MAX[1] - cur_angle[1];
  assign span[2] = AXIS_MAX[2] - cur_angle[2];
  assign span[3] = cur_angle[3];
  assign span[4] = cur_angle[4];

  assign prod[0] = PROD_W'(span[0]) * PROD_W'(MUL_AX1);
  assign prod[1] = PROD_W'(span[1]) * PROD_W'(MUL_AX2);
  assign prod[2] = PROD_W'(span[2]) * PROD_W'(MUL_AX3);
  assign prod[3] = PROD_W'(span[3]) * PROD_W'(MUL_AX4);
  assign prod[4] = PROD_W'(span[4]) * PROD_W'(MUL_AX5);

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      quot[i] = prod[i][MAP_SHIFT +: CMP_W];
    end
  end

  always_comb begin
    result.compare_axis1 = quot[0] + OFF_AX1;
    result.compare_axis2 = quot[1] + OFF_AX2;
    result.compare_axis3 = quot[2] + OFF_AX3;
    result.compare_axis4 = quot[3] + OFF_AX4;
    result.compare_axis5 = quot[4] + OFF_AX5;
    result.settled       = (cur_angle == tgt_angle);
  end

endmodule

@@ hw/rtl/mssp_fifo.sv @@
// Result queue that decouples the update stage from a stalled consumer.
`timescale 1ns / 1ps

module mssp_fifo
  import mssp_pkg::*;
#(
  parameter int DEPTH = RES_DEPTH_DEF
)
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  rsp_item_t                  push_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output rsp_item_t                  out_item,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rsp_item_t         slots [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic              pop;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
    return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign out_valid = (count != '0);
  assign out_item  = slots[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

@@ hw/rtl/multi_axis_servo_slew_pwm.sv @@
// Top level: five-axis servo slew limiter with per-axis PWM compare mapping.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------------
//   req      | in        | req_valid/req_stall  | cmd, axis_index, angle
//   rsp      | out       | rsp_valid/rsp_stall  | five compare values, settled flag
//
// One item per cycle is taken while req_stall is low.
// The accepting edge updates the angle registers, which feed the mapping
// multipliers; the next edge writes the result queue.
// Reset clears all angles to zero and empties the queue; there is no clearing pass.
// req_stall rises when the queued results plus the item in flight would fill the
// RES_DEPTH-entry queue, so a stalled consumer backs up after RES_DEPTH items.
`timescale 1ns / 1ps

module multi_axis_servo_slew_pwm
  import mssp_pkg::*;
#(
  parameter int RES_DEPTH = RES_DEPTH_DEF
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  localparam int CW = $clog2(RES_DEPTH + 1);

  angle_vec_t         cur_angle;
  angle_vec_t         tgt_angle;
  angle_vec_t         cur_angle_next;
  angle_vec_t         tgt_angle_next;
  logic [ANGLE_W-1:0] sat_angle [NUM_AXES];
  logic               accept;
  logic               upd_valid;
  logic [CW-1:0]      q_count;
  logic [CW:0]        q_fill;
  rsp_item_t          map_result;

  assign accept    = req_valid && !req_stall;
  assign q_fill    = {1'b0, q_count} + {{CW{1'b0}}, upd_valid};
  assign req_stall = (q_fill >= (CW+1)'(RES_DEPTH));

  always_comb begin
    cur_angle_next = cur_angle;
    tgt_angle_next = tgt_angle;
    for (int i = 0; i < NUM_AXES; i++) begin
      sat_angle[i] = (req.angle > AXIS_MAX[i]) ? AXIS_MAX[i] : req.angle;
    end
    if (accept) begin
      case (req.cmd) inside
        CMD_SET_TARGET, CMD_SET_BOTH: begin
          // An index beyond the last axis matches nothing and changes no state.
          for (int i = 0; i < NUM_AXES; i++) begin
            if (req.axis_index == AXIS_W'(i)) begin
              tgt_angle_next[i] = sat_angle[i];
              if (req.cmd == CMD_SET_BOTH) begin
                cur_angle_next[i] = sat_angle[i];
              end
            end
          end
        end
        CMD_TICK: begin
          for (int i = 0; i < NUM_AXES; i++) begin
            if (tgt_angle[i] > cur_angle[i]) begin
              cur_angle_next[i] = cur_angle[i] + 1'b1;
            end else if (tgt_angle[i] < cur_angle[i]) begin
              cur_angle_next[i] = cur_angle[i] - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_angle <= '0;
      tgt_angle <= '0;
      upd_valid <= 1'b0;
    end else begin
      cur_angle <= cur_angle_next;
      tgt_angle <= tgt_angle_next;
      upd_valid <= accept;
    end
  end

  // The angle registers hold the state after the item in flight, so the map
  // output is that item's result when upd_valid is high.
  mssp_map u_map (
    .cur_angle (cur_angle),
    .tgt_angle (tgt_angle),
    .result    (map_result)
  );

  mssp_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (upd_valid),
    .push_item (map_result),
    .out_valid (rsp_valid),
    .out_stall (rsp_stall),
    .out_item  (rsp),
    .count     (q_count)
  );

endmodule

@@ hw/rtl/mssp_checker.sv @@
// Port-level checks for the servo slew limiter, bound to the top level.
`timescale 1ns / 1ps

module mssp_checker
  import mssp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input req_item_t req,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input rsp_item_t rsp
);

  // A result held by the consumer stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // With no result waiting, the queue cannot be near full.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> !req_stall)
    else $error("input stalled with an empty result queue");

  // An item taken while no result waits shows up once the angle registers and then the result queue are written.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && !rsp_valid |=> ##1 rsp_valid)
    else $error("result missing two cycles after acceptance");

  // Stored angles never pass the axis maxima, so compares stay within their maps.
  a_compare_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.compare_axis1 >= 8'd55 && rsp.compare_axis2 >= 8'd50 &&
                  rsp.compare_axis2 <= 8'd240 && rsp.compare_axis3 >= 8'd50 &&
                  rsp.compare_axis3 <= 8'd225 && rsp.compare_axis4 >= 8'd55 &&
                  rsp.compare_axis4 <= 8'd230 && rsp.compare_axis5 >= 8'd50 &&
                  rsp.compare_axis5 <= 8'd250)
    else $error("compare value outside its map range");

endmodule

bind multi_axis_servo_slew_pwm mssp_checker u_mssp_checker (.*);

@@ bench/tb.sv @@
// Self-checking testbench for the five-axis servo slew limiter with PWM mapping.
`timescale 1ns / 1ps

module tb;
  import mssp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_CAP    = 40;

  typedef struct {
    req_item_t item;
    bit        typed;
    rsp_item_t want;
  } servo_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  // Predicted servo state, updated at each accepted item.
  logic [ANGLE_W-1:0] pos_now  [NUM_AXES];
  logic [ANGLE_W-1:0] pos_goal [NUM_AXES];

  rsp_item_t  pwm_expected [$];
  servo_row_t servo_plan [$];

  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int results_seen = 0;
  int settled_seen = 0;
  int saturated_writes = 0;
  int ignored_writes = 0;
  int input_stall_cycles = 0;
  int burst_left = 0;
  int pressure_left = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_left = 0;
  int rx_phase = 0;

  multi_axis_servo_slew_pwm dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("multi_axis_servo_slew_pwm: mismatch");
      $finish;
    end
  end

  function automatic rsp_item_t mk_rsp(int c1, int c2, int c3, int c4, int c5, bit s);
    rsp_item_t y;
    y.compare_axis1 = CMP_W'(c1);
    y.compare_axis2 = CMP_W'(c2);
    y.compare_axis3 = CMP_W'(c3);
    y.compare_axis4 = CMP_W'(c4);
    y.compare_axis5 = CMP_W'(c5);
    y.settled       = s;
    return y;
  endfunction

  // Applies one item to the predicted state and returns the PWM compare set it yields.
  task automatic servo_predict(input req_item_t r, output rsp_item_t y);
    logic [ANGLE_W-1:0] a;
    bit s;
    s = 1'b1;
    if (r.cmd == CMD_SET_TARGET || r.cmd == CMD_SET_BOTH) begin
      if (r.axis_index < NUM_AXES) begin
        a = r.angle;
        if (a > AXIS_MAX[r.axis_index]) begin
          a = AXIS_MAX[r.axis_index];
          saturated_writes++;
        end
        pos_goal[r.axis_index] = a;
        if (r.cmd == CMD_SET_BOTH) pos_now[r.axis_index] = a;
      end else begin
        ignored_writes++;
      end
    end else if (r.cmd == CMD_TICK) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if (pos_goal[i] > pos_now[i]) pos_now[i] = pos_now[i] + 1'b1;
        else if (pos_goal[i] < pos_now[i]) pos_now[i] = pos_now[i] - 1'b1;
      end
    end else begin
      ignored_writes++;
    end
    for (int i = 0; i < NUM_AXES; i++)
      if (pos_now[i] != pos_goal[i]) s = 1'b0;
    // The first three axes are mounted reversed, so their maps run from the maximum down.
    y = mk_rsp((270 - int'(pos_now[0])) * 200 / 270 + 55,
               (180 - int'(pos_now[1])) * 190 / 180 + 50,
               (270 - int'(pos_now[2])) * 175 / 270 + 50,
               int'(pos_now[3]) * 175 / 270 + 55,
               int'(pos_now[4]) * 200 / 180 + 50,
               s);
  endtask

  task automatic report(string field, int got, int want);
    if (errors < PRINT_CAP)
      $display("[%0t] result %0d: %s is %0d, expected %0d", $realtime, results_seen, field,
               got, want);
    errors++;
  endtask

  task automatic add_row(logic [CMD_W-1:0] cmd, int ax, int ang, bit typed, rsp_item_t want);
    servo_row_t row;
    row.item.cmd        = cmd;
    row.item.axis_index = AXIS_W'(ax);
    row.item.angle      = ANGLE_W'(ang);
    row.typed           = typed;
    row.want            = want;
    servo_plan.push_back(row);
  endtask

  // Offers one item, holds it until accepted, then books its expected result and may pause before the next item.
  task automatic send_item(req_item_t r, bit typed, rsp_item_t want);
    rsp_item_t predicted;
    int gap;
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    servo_predict(r, predicted);
    pwm_expected.push_back(typed ? want : predicted);
    items_sent++;
    if (pressure_left > 0) begin
      pressure_left--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Result side: checks each accepted result and stalls on its own schedule.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_stall) input_stall_cycles++;
      if (rsp_valid && !rsp_stall) begin
        if (pwm_expected.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          rsp_item_t want;
          want = pwm_expected.pop_front();
          if (rsp.compare_axis1 !== want.compare_axis1)
            report("compare_axis1", rsp.compare_axis1, want.compare_axis1);
          if (rsp.compare_axis2 !== want.compare_axis2)
            report("compare_axis2", rsp.compare_axis2, want.compare_axis2);
          if (rsp.compare_axis3 !== want.compare_axis3)
            report("compare_axis3", rsp.compare_axis3, want.compare_axis3);
          if (rsp.compare_axis4 !== want.compare_axis4)
            report("compare_axis4", rsp.compare_axis4, want.compare_axis4);
          if (rsp.compare_axis5 !== want.compare_axis5)
            report("compare_axis5", rsp.compare_axis5, want.compare_axis5);
          if (rsp.settled !== want.settled)
            report("settled", rsp.settled, want.settled);
          if (want.settled) settled_seen++;
        end
        results_seen++;
      end
      rx_phase <= rx_phase + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_stall <= 1'b1;
      end else if (hold_go && !hold_done) begin
        // Long hold-off so the result queue fills and the input backs up.
        hold_done <= 1'b1;
        hold_left <= 80;
        rsp_stall <= 1'b1;
      end else begin
        if (rx_left == 0) begin
          rx_mode <= $urandom_range(0, 3);
          rx_left <= $urandom_range(40, 300);
        end else begin
          rx_left <= rx_left - 1;
        end
        case (rx_mode)
          0: rsp_stall <= 1'b0;
          1: rsp_stall <= ($urandom_range(0, 99) < 30);
          2: rsp_stall <= ($urandom_range(0, 99) < 75);
          default: rsp_stall <= (rx_phase % 7) < 3;
        endcase
      end
    end
  end

  initial begin
    req_item_t r;
    int kind;
    int ax;
    int ang;
    int n;
    int random_start;

    for (int i = 0; i < NUM_AXES; i++) begin
      pos_now[i]  = '0;
      pos_goal[i] = '0;
    end

    // Directed part: reset state, saturation and writes at the axis maxima, ignored writes, slewing.
    add_row(CMD_TICK,       7, 511, 1, mk_rsp(255, 240, 225, 55, 50, 1));
    add_row(CMD_SET_BOTH,   0, 511, 1, mk_rsp(55, 240, 225, 55, 50, 1));
    add_row(CMD_SET_BOTH,   1, 511, 1, mk_rsp(55, 50, 225, 55, 50, 1));
    add_row(CMD_SET_BOTH,   2, 270, 1, mk_rsp(55, 50, 50, 55, 50, 1));
    add_row(CMD_SET_BOTH,   3, 271, 1, mk_rsp(55, 50, 50, 230, 50, 1));
    add_row(CMD_SET_BOTH,   4, 180, 1, mk_rsp(55, 50, 50, 230, 250, 1));
    add_row(CMD_SET_TARGET, 0, 0,   1, mk_rsp(55, 50, 50, 230, 250, 0));
    add_row(CMD_SET_TARGET, 5, 100, 1, mk_rsp(55, 50, 50, 230, 250, 0));
    add_row(CMD_UNUSED,     1, 0,   1, mk_rsp(55, 50, 50, 230, 250, 0));
    add_row(CMD_SET_BOTH,   7, 0,   1, mk_rsp(55, 50, 50, 230, 250, 0));
    add_row(CMD_TICK,       3, 5,   0, '0);
    add_row(CMD_SET_BOTH,   0, 0,   1, mk_rsp(255, 50, 50, 230, 250, 1));
    add_row(CMD_SET_TARGET, 1, 179, 0, '0);
    add_row(CMD_TICK,       0, 0,   0, '0);
    add_row(CMD_SET_TARGET, 4, 0,   0, '0);
    add_row(CMD_TICK,       6, 256, 0, '0);
    add_row(CMD_TICK,       1, 1,   0, '0);
    add_row(CMD_SET_TARGET, 3, 1,   0, '0);
    add_row(CMD_SET_BOTH,   2, 135, 0, '0);
    add_row(CMD_TICK,       2, 170, 0, '0);
    add_row(CMD_SET_BOTH,   1, 0,   0, '0);
    add_row(CMD_SET_BOTH,   2, 0,   0, '0);
    add_row(CMD_SET_BOTH,   3, 0,   0, '0);
    add_row(CMD_SET_BOTH,   4, 0,   1, mk_rsp(255, 240, 225, 55, 50, 1));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (servo_plan[i])
      send_item(servo_plan[i].item, servo_plan[i].typed, servo_plan[i].want);

    random_start = items_sent;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      if (!hold_go && items_sent >= random_start + 200) begin
        hold_go       <= 1'b1;
        pressure_left = 60;
      end
      // A stretch in which the first item of each step goes out with no sender gap.
      if (items_sent >= random_start + 700 && items_sent < random_start + 760)
        pressure_left = 1;
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        r.cmd        = CMD_W'($urandom_range(0, 3));
        r.axis_index = AXIS_W'($urandom_range(0, 7));
        r.angle      = ANGLE_W'($urandom_range(0, 511));
        send_item(r, 1'b0, '0);
      end else if (kind < 20) begin
        r.cmd        = CMD_SET_BOTH;
        r.axis_index = AXIS_W'($urandom_range(0, NUM_AXES - 1));
        r.angle      = ANGLE_W'($urandom_range(0, 511));
        send_item(r, 1'b0, '0);
      end else begin
        // A short move: nearby targets on a few axes, then ticks toward them.
        n = $urandom_range(1, 3);
        repeat (n) begin
          ax = $urandom_range(0, NUM_AXES - 1);
          if ($urandom_range(0, 7) == 0)
            ang = int'(AXIS_MAX[ax]) + $urandom_range(0, 3);
          else
            ang = int'(pos_now[ax]) + $urandom_range(0, 24) - 12;
          if (ang < 0) ang = 0;
          r.cmd        = CMD_SET_TARGET;
          r.axis_index = AXIS_W'(ax);
          r.angle      = ANGLE_W'(ang);
          send_item(r, 1'b0, '0);
        end
        n = $urandom_range(0, 16);
        repeat (n) begin
          r.cmd        = CMD_TICK;
          r.axis_index = AXIS_W'($urandom_range(0, 7));
          r.angle      = ANGLE_W'($urandom_range(0, 511));
          send_item(r, 1'b0, '0);
        end
      end
    end
    req_valid <= 1'b0;

    while (pwm_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d items and %0d results, %0d of them settled.", items_sent,
             results_seen, settled_seen);
    $display("Saturated writes %0d, ignored writes %0d, input stall cycles %0d.",
             saturated_writes, ignored_writes, input_stall_cycles);
    if (errors == 0) begin
      $display("multi_axis_servo_slew_pwm: match");
    end else begin
      $display("multi_axis_servo_slew_pwm: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/mssp_pkg.sv
hw/rtl/mssp_map.sv
hw/rtl/mssp_fifo.sv
hw/rtl/multi_axis_servo_slew_pwm.sv
hw/rtl/mssp_checker.sv
bench/tb.sv
